[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the relay interlock checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising edge, switched off while reset is low
`define RIFM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion sampled on the rising edge, also live during reset
`define RIFM_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rifm_pkg.sv]
// ----------------------------------------------------------------------------
// rifm_pkg
// Types and constants shared by the relay interlock and fault monitor.
// ----------------------------------------------------------------------------
package rifm_pkg;

  // Field widths
  localparam int FIELD_W = 10;
  localparam int CNT_W   = 4;
  localparam int OP_W    = 3;

  // Mismatch limit after reset
  localparam logic [CNT_W-1:0] LIMIT_RST = 4'd5;

  // Relay positions in the drive word
  localparam int RLY_CT_EN  = 0;
  localparam int RLY_CT_DIS = 1;
  localparam int RLY_FE_EN  = 2;
  localparam int RLY_FE_DIS = 3;
  localparam int RLY_CT_ACT = 4;
  localparam int RLY_FE_ACT = 5;
  localparam int RLY_AUX1   = 6;
  localparam int RLY_AUX2   = 7;
  localparam int RLY_AUX3   = 8;
  localparam int RLY_AUX4   = 9;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ALARM_EN = 3'd0,
    OP_CT_ACT   = 3'd1,
    OP_FE_ACT   = 3'd2,
    OP_REMOTE   = 3'd3,
    OP_CHECK    = 3'd4
  } op_t;

  // One registered input word
  typedef struct packed {
    op_t                op;
    logic               req;
    logic [FIELD_W-1:0] rb;
  } item_t;

endpackage

[sv/rifm_cmd.sv]
// ----------------------------------------------------------------------------
// rifm_cmd
// Commanded relay state with the alarm-enable interlock on the active relays.
// ----------------------------------------------------------------------------
module rifm_cmd
  import rifm_pkg::*;
#(
  parameter int RELAY_COUNT = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   upd,
  input  item_t                  item,
  output logic [RELAY_COUNT-1:0] cmd_cur,
  output logic [RELAY_COUNT-1:0] cmd_nxt
);

  logic [RELAY_COUNT-1:0] cmd_r;
  logic                   ct_gate;
  logic                   fe_gate;

  // Interlock: active relay only with both matching enables on
  assign ct_gate = item.req & cmd_r[RLY_CT_EN] & cmd_r[RLY_CT_DIS];
  assign fe_gate = item.req & cmd_r[RLY_FE_EN] & cmd_r[RLY_FE_DIS];

  // Next commanded state
  always_comb begin
    cmd_nxt = cmd_r;
    unique case (item.op)
      OP_ALARM_EN: begin
        cmd_nxt[RLY_CT_EN]  = item.req;
        cmd_nxt[RLY_CT_DIS] = item.req;
        cmd_nxt[RLY_FE_EN]  = item.req;
        cmd_nxt[RLY_FE_DIS] = item.req;
        cmd_nxt[RLY_AUX1]   = item.req;
      end
      OP_CT_ACT: begin
        cmd_nxt[RLY_CT_ACT] = ct_gate;
        cmd_nxt[RLY_AUX2]   = ct_gate;
      end
      OP_FE_ACT: begin
        cmd_nxt[RLY_FE_ACT] = fe_gate;
        cmd_nxt[RLY_AUX3]   = fe_gate;
      end
      OP_REMOTE: begin
        cmd_nxt[RLY_AUX4] = item.req;
      end
      default: begin
        cmd_nxt = cmd_r;
      end
    endcase
  end

  // Commanded state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= '0;
    end else if (upd) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_cur = cmd_r;

endmodule

[sv/rifm_mon.sv]
// ----------------------------------------------------------------------------
// rifm_mon
// Per-relay consecutive mismatch counters and fault detection on check.
// ----------------------------------------------------------------------------
module rifm_mon
  import rifm_pkg::*;
#(
  parameter int RELAY_COUNT = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   upd,
  input  item_t                  item,
  input  logic [RELAY_COUNT-1:0] cmd_cur,
  input  logic [CNT_W-1:0]       limit,
  output logic [RELAY_COUNT-1:0] fault_nxt
);

  logic [CNT_W-1:0]       cnt_r   [RELAY_COUNT];
  logic [CNT_W-1:0]       cnt_nxt [RELAY_COUNT];
  logic [CNT_W-1:0]       cnt_inc [RELAY_COUNT];
  logic [RELAY_COUNT-1:0] rb_ext;
  logic [RELAY_COUNT-1:0] mism;
  logic                   is_check;

  // Relays above the readback word read back as off
  assign rb_ext   = RELAY_COUNT'(item.rb);
  assign mism     = rb_ext ^ cmd_cur;
  assign is_check = (item.op == OP_CHECK);

  // Counter update, one independent lane per relay
  always_comb begin
    for (int i = 0; i < RELAY_COUNT; i++) begin
      cnt_inc[i]   = cnt_r[i] + CNT_W'(1);
      cnt_nxt[i]   = cnt_r[i];
      fault_nxt[i] = 1'b0;
      if (is_check) begin
        if (mism[i]) begin
          if (cnt_inc[i] >= limit) begin
            cnt_nxt[i]   = '0;
            fault_nxt[i] = 1'b1;
          end else begin
            cnt_nxt[i] = cnt_inc[i];
          end
        end else begin
          cnt_nxt[i] = '0;
        end
      end
    end
  end

  // Counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RELAY_COUNT; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (upd) begin
      for (int i = 0; i < RELAY_COUNT; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

endmodule

[sv/relay_interlock_fault_monitor.sv]
// A word accepted at the input passes the input register, then the result
// register, before it shows on the out_ ports. Throughput: one word per cycle
// while out_ready is high; all relay lanes update together in one pass.
// Reset (rst_n low, synchronous): relays all off, mismatch counters zero,
// mismatch limit back to 5, both stages empty.
// ----------------------------------------------------------------------------
// relay_interlock_fault_monitor
// Ten-relay command interlock with readback mismatch fault monitoring.
// ----------------------------------------------------------------------------
module relay_interlock_fault_monitor
  import rifm_pkg::*;
#(
  parameter int RELAY_COUNT = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_operation,
  input  logic               in_request,
  input  logic [FIELD_W-1:0] in_readback,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] out_relay_drive,
  output logic [FIELD_W-1:0] out_fault_mask,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [CNT_W-1:0]   cfg_wr_data
);

  logic                   s1_vld_r;
  item_t                  item_r;
  logic                   s1_adv;
  logic                   in_fire;
  logic                   out_vld_r;
  logic [FIELD_W-1:0]     drive_r;
  logic [FIELD_W-1:0]     fault_r;
  logic [CNT_W-1:0]       limit_r;
  logic [RELAY_COUNT-1:0] cmd_cur;
  logic [RELAY_COUNT-1:0] cmd_nxt;
  logic [RELAY_COUNT-1:0] fault_nxt;

  // Handshake between the two stages
  assign s1_adv   = s1_vld_r & (~out_vld_r | out_ready);
  assign in_ready = ~s1_vld_r | s1_adv;
  assign in_fire  = in_valid & in_ready;

  // Mismatch limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.op  <= op_t'(in_operation);
      item_r.req <= in_request;
      item_r.rb  <= in_readback;
    end
  end

  // Command logic and commanded state
  rifm_cmd #(
    .RELAY_COUNT(RELAY_COUNT)
  ) u_cmd (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (s1_adv),
    .item    (item_r),
    .cmd_cur (cmd_cur),
    .cmd_nxt (cmd_nxt)
  );

  // Readback monitor
  rifm_mon #(
    .RELAY_COUNT(RELAY_COUNT)
  ) u_mon (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (s1_adv),
    .item      (item_r),
    .cmd_cur   (cmd_cur),
    .limit     (limit_r),
    .fault_nxt (fault_nxt)
  );

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      drive_r <= cmd_nxt[FIELD_W-1:0];
      fault_r <= fault_nxt[FIELD_W-1:0];
    end
  end

  assign out_valid       = out_vld_r;
  assign out_relay_drive = drive_r;
  assign out_fault_mask  = fault_r;

endmodule

[sv/rifm_checker.sv]
// ----------------------------------------------------------------------------
// rifm_checker
// Port-level checks on the relay interlock and fault monitor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rifm_checker
  import rifm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [OP_W-1:0]    in_operation,
  input logic               in_request,
  input logic [FIELD_W-1:0] in_readback,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FIELD_W-1:0] out_relay_drive,
  input logic [FIELD_W-1:0] out_fault_mask,
  input logic               cfg_wr_en,
  input logic [CNT_W-1:0]   cfg_wr_data
);

  // A stalled result word holds
  `RIFM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_relay_drive) && $stable(out_fault_mask), "result word changed while stalled")

  // Alarm-enable group always moves together
  `RIFM_ASSERT(a_en_group, clk, rst_n, out_valid |-> (out_relay_drive[RLY_CT_EN] == out_relay_drive[RLY_CT_DIS]) && (out_relay_drive[RLY_CT_EN] == out_relay_drive[RLY_FE_EN]) && (out_relay_drive[RLY_CT_EN] == out_relay_drive[RLY_FE_DIS]) && (out_relay_drive[RLY_CT_EN] == out_relay_drive[RLY_AUX1]), "alarm enable relays disagree")

  // Active relays and their auxiliaries are driven as pairs
  `RIFM_ASSERT(a_act_pairs, clk, rst_n, out_valid |-> (out_relay_drive[RLY_CT_ACT] == out_relay_drive[RLY_AUX2]) && (out_relay_drive[RLY_FE_ACT] == out_relay_drive[RLY_AUX3]), "active relay and auxiliary disagree")

  // A free result side never blocks the input
  `RIFM_ASSERT(a_no_block, clk, rst_n, out_ready |-> in_ready, "input stalled with result side ready")

  // Reset empties the result stage
  `RIFM_ASSERT_RST(a_rst_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind relay_interlock_fault_monitor rifm_checker u_rifm_checker (.*);

[verif/relay_interlock_fault_monitor_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// relay_interlock_fault_monitor_test
// Self-checking testbench for the relay interlock and fault monitor. A short
// table of directed words covers the command interlocks, the spare operation
// codes and a fault at the reset limit. It is followed by random phases, each
// at a fresh mismatch limit (0, 1, 5, 15, lowered below live counts, random).
// Every accepted word is run through a local model of the relays and
// counters. Each result word is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module relay_interlock_fault_monitor_test;
  import rifm_pkg::*;

  // Spare operation codes, which change nothing
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int N_PHASES     = 8;
  localparam int PHASE_WORDS  = 175;
  localparam int STALL_LIMIT  = 1000;
  localparam int N_DIRECTED   = 23;

  typedef struct packed {
    logic [FIELD_W-1:0] drive;
    logic [FIELD_W-1:0] fault;
  } relay_result_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               req;
    logic [FIELD_W-1:0] rb;
    logic               known;
    logic [FIELD_W-1:0] drive;
    logic [FIELD_W-1:0] fault;
  } directed_row_t;

  // Directed words; known results are typed in, the rest come from the model
  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{OP_CHECK,    1'b0, 10'h000, 1'b1, 10'h000, 10'h000}, // all off, all match
    '{OP_CHECK,    1'b0, 10'h3FF, 1'b1, 10'h000, 10'h000}, // first mismatch
    '{OP_ALARM_EN, 1'b1, 10'h000, 1'b1, 10'h04F, 10'h000},
    '{OP_CT_ACT,   1'b1, 10'h3FF, 1'b1, 10'h0DF, 10'h000},
    '{OP_FE_ACT,   1'b1, 10'h000, 1'b1, 10'h1FF, 10'h000},
    '{OP_REMOTE,   1'b1, 10'h2AA, 1'b1, 10'h3FF, 10'h000},
    '{OP_SPARE_5,  1'b0, 10'h000, 1'b1, 10'h3FF, 10'h000},
    '{OP_SPARE_6,  1'b1, 10'h3FF, 1'b1, 10'h3FF, 10'h000},
    '{OP_SPARE_7,  1'b1, 10'h155, 1'b1, 10'h3FF, 10'h000},
    '{OP_ALARM_EN, 1'b0, 10'h3FF, 1'b1, 10'h3B0, 10'h000},
    '{OP_CT_ACT,   1'b1, 10'h000, 1'b1, 10'h320, 10'h000}, // interlock closed
    '{OP_FE_ACT,   1'b0, 10'h155, 1'b1, 10'h200, 10'h000},
    '{OP_REMOTE,   1'b0, 10'h3FF, 1'b1, 10'h000, 10'h000},
    '{OP_CHECK,    1'b0, 10'h3FF, 1'b1, 10'h000, 10'h000},
    '{OP_CHECK,    1'b1, 10'h3FF, 1'b1, 10'h000, 10'h000},
    '{OP_CHECK,    1'b0, 10'h3FF, 1'b1, 10'h000, 10'h000},
    '{OP_CHECK,    1'b1, 10'h3FF, 1'b1, 10'h000, 10'h3FF}, // fifth in a row
    '{OP_CHECK,    1'b0, 10'h155, 1'b0, 10'h000, 10'h000},
    '{OP_CHECK,    1'b0, 10'h000, 1'b0, 10'h000, 10'h000},
    '{OP_ALARM_EN, 1'b1, 10'h000, 1'b0, 10'h000, 10'h000},
    '{OP_CT_ACT,   1'b0, 10'h000, 1'b0, 10'h000, 10'h000},
    '{OP_FE_ACT,   1'b1, 10'h3FF, 1'b0, 10'h000, 10'h000},
    '{OP_CHECK,    1'b0, 10'h2AA, 1'b0, 10'h000, 10'h000}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [OP_W-1:0]    in_operation;
  logic               in_request;
  logic [FIELD_W-1:0] in_readback;
  logic               out_valid;
  logic               out_ready;
  logic [FIELD_W-1:0] out_relay_drive;
  logic [FIELD_W-1:0] out_fault_mask;
  logic               cfg_wr_en;
  logic [CNT_W-1:0]   cfg_wr_data;

  // Local copy of the relay state, counters and limit
  logic [FIELD_W-1:0] relay_cmd;
  logic [CNT_W-1:0]   miss_count [FIELD_W];
  logic [CNT_W-1:0]   fault_limit;

  relay_result_t expected_results [$];
  int                 error_count;
  int                 burst_left;
  int                 quiet_cycles;
  int                 ready_left;
  int                 ready_mode;
  logic [7:0]         ready_pattern;

  relay_interlock_fault_monitor u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_request      (in_request),
    .in_readback     (in_readback),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_relay_drive (out_relay_drive),
    .out_fault_mask  (out_fault_mask),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one word to the local relay model and return its result
  function automatic relay_result_t step_relay_model(input logic [OP_W-1:0] op,
                                                     input logic req,
                                                     input logic [FIELD_W-1:0] rb);
    relay_result_t    res;
    logic             gate;
    logic [CNT_W-1:0] cnt;
    res.fault = '0;
    unique case (op)
      OP_ALARM_EN: begin
        relay_cmd[RLY_CT_EN]  = req;
        relay_cmd[RLY_CT_DIS] = req;
        relay_cmd[RLY_FE_EN]  = req;
        relay_cmd[RLY_FE_DIS] = req;
        relay_cmd[RLY_AUX1]   = req;
      end
      OP_CT_ACT: begin
        gate = req & relay_cmd[RLY_CT_EN] & relay_cmd[RLY_CT_DIS];
        relay_cmd[RLY_CT_ACT] = gate;
        relay_cmd[RLY_AUX2]   = gate;
      end
      OP_FE_ACT: begin
        gate = req & relay_cmd[RLY_FE_EN] & relay_cmd[RLY_FE_DIS];
        relay_cmd[RLY_FE_ACT] = gate;
        relay_cmd[RLY_AUX3]   = gate;
      end
      OP_REMOTE: begin
        relay_cmd[RLY_AUX4] = req;
      end
      OP_CHECK: begin
        for (int i = 0; i < FIELD_W; i++) begin
          if (rb[i] != relay_cmd[i]) begin
            cnt = miss_count[i] + CNT_W'(1);
            if (cnt >= fault_limit) begin
              cnt          = '0;
              res.fault[i] = 1'b1;
            end
            miss_count[i] = cnt;
          end else begin
            miss_count[i] = '0;
          end
        end
      end
      default: ;
    endcase
    res.drive = relay_cmd;
    return res;
  endfunction

  // Offer one word, in bursts with random gaps, and log its expected result
  task automatic send_word(input logic [OP_W-1:0] op, input logic req,
                           input logic [FIELD_W-1:0] rb, input logic known,
                           input relay_result_t typed);
    relay_result_t predicted;
    int            gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_request   <= req;
    in_readback  <= rb;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = step_relay_model(op, req, rb);
    expected_results.push_back(known ? typed : predicted);
  endtask

  // Hold off until every result word is back and the pipe has emptied
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    fault_limit = value;
  endtask

  // Result checker and watchdog
  always @(posedge clk) begin
    relay_result_t exp_word;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, drive %h fault %h",
                   $time, out_relay_drive, out_fault_mask);
          error_count++;
        end else begin
          exp_word = expected_results.pop_front();
          if (out_relay_drive !== exp_word.drive) begin
            $display("%0t: relay_drive mismatch, expected %h, got %h",
                     $time, exp_word.drive, out_relay_drive);
            error_count++;
          end
          if (out_fault_mask !== exp_word.fault) begin
            $display("%0t: fault_mask mismatch, expected %h, got %h",
                     $time, exp_word.fault, out_fault_mask);
            error_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Receiver back-pressure: always ready, random, or a rotating pattern
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_left    = $urandom_range(4, 60);
      ready_mode    = $urandom_range(0, 2);
      ready_pattern = 8'($urandom_range(1, 255));
    end
    ready_left--;
    ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
    unique case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 99) < 60);
      default: out_ready <= ready_pattern[0];
    endcase
  end

  // Main stimulus
  initial begin
    logic [CNT_W-1:0]   phase_limit;
    logic [FIELD_W-1:0] stuck_mask;
    logic [FIELD_W-1:0] noise;
    logic [OP_W-1:0]    op;
    logic               req;
    logic [FIELD_W-1:0] rb;
    int                 pick;
    relay_result_t      typed;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = '0;
    in_request   = 1'b0;
    in_readback  = '0;
    out_ready    = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    error_count  = 0;
    burst_left   = 0;
    quiet_cycles = 0;
    ready_left   = 0;
    relay_cmd    = '0;
    fault_limit  = LIMIT_RST;
    for (int i = 0; i < FIELD_W; i++) miss_count[i] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table at the reset limit
    for (int r = 0; r < N_DIRECTED; r++) begin
      typed.drive = DIRECTED_ROWS[r].drive;
      typed.fault = DIRECTED_ROWS[r].fault;
      send_word(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].rb,
                DIRECTED_ROWS[r].known, typed);
    end

    // Random phases; 15 then 2 lowers the limit below counts left running
    for (int ph = 0; ph < N_PHASES; ph++) begin
      unique case (ph)
        0:       phase_limit = 4'd15;
        1:       phase_limit = 4'd2;
        2:       phase_limit = 4'd0;
        3:       phase_limit = 4'd1;
        4:       phase_limit = LIMIT_RST;
        6:       phase_limit = 4'd15;
        default: phase_limit = CNT_W'($urandom_range(1, 15));
      endcase
      drain_results();
      write_limit(phase_limit);
      // random relays stick for the whole phase, all in the first, so counters build up
      stuck_mask = FIELD_W'($urandom_range(0, 1023) & $urandom_range(0, 1023));
      if (ph == 0) stuck_mask = 10'h3FF;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick = $urandom_range(0, 99);
        req  = 1'($urandom_range(0, 1));
        rb   = FIELD_W'($urandom_range(0, 1023));
        if (pick < 45) begin
          op    = OP_CHECK;
          noise = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023)) : '0;
          rb    = relay_cmd ^ stuck_mask ^ noise;
        end else if (pick < 57) begin
          op  = OP_ALARM_EN;
          req = ($urandom_range(0, 4) != 0);
        end else if (pick < 69) begin
          op = OP_CT_ACT;
        end else if (pick < 81) begin
          op = OP_FE_ACT;
        end else if (pick < 93) begin
          op = OP_REMOTE;
        end else begin
          op = OP_W'($urandom_range(5, 7));
        end
        send_word(op, req, rb, 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/rifm_pkg.sv
sv/rifm_cmd.sv
sv/rifm_mon.sv
sv/relay_interlock_fault_monitor.sv
sv/rifm_checker.sv
verif/relay_interlock_fault_monitor_test.sv
